>>> rtl/luddl_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// luddl_pkg: shared types and constants for the LU decomposition block
// Controller commands, datapath status, state encoding and fixed widths.
// ----------------------------------------------------------------------------
package luddl_pkg;

   localparam int VAL_W     = 32;       // Q16.16 word
   localparam int IDX_W     = 2;        // row / column index
   localparam int DIV_STEPS = 48;       // quotient bits of (a * 2^16) / d
   localparam int DCNT_W    = 6;
   localparam logic [VAL_W-1:0] ONE_Q16 = 32'h0001_0000;

   typedef enum logic [3:0] {
      OP_IDLE,
      OP_START,
      OP_COPY,
      OP_DIV_START,
      OP_DIV_RUN,
      OP_WRITE_L,
      OP_MUL,
      OP_RND,
      OP_SUB,
      OP_EMIT
   } dp_op_type;

   typedef enum logic [3:0] {
      ST_IDLE,
      ST_COPY,
      ST_DIV_START,
      ST_DIV_RUN,
      ST_WRITE_L,
      ST_MUL,
      ST_RND,
      ST_SUB,
      ST_EMIT
   } ctrl_state_type;

   typedef struct packed {
      dp_op_type        op;
      logic [IDX_W-1:0] k;
      logic [IDX_W-1:0] i;
      logic [IDX_W-1:0] j;
      logic             half;
      logic             final_res;
   } dp_cmd_type;

   typedef struct packed {
      logic div_done;
      logic out_free;
   } dp_status_type;

endpackage
`default_nettype wire

>>> rtl/luddl_ctrl.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// luddl_ctrl: sequencer for load, elimination and result streaming
// Walks pivot column k, row i and column j and issues one datapath op a cycle.
// ----------------------------------------------------------------------------
module luddl_ctrl #(
   parameter int MATRIX_SIZE = 3
) (
   input  wire                      clock,
   input  wire                      reset,
   input  wire                      req_fire,
   input  wire                      req_last,
   output logic                     req_ready,
   input  luddl_pkg::dp_status_type status,
   output luddl_pkg::dp_cmd_type    cmd
);
   import luddl_pkg::*;

   localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(MATRIX_SIZE - 1);

   ctrl_state_type   state_ff, state_in;
   logic [IDX_W-1:0] k_ff, k_in, i_ff, i_in, j_ff, j_in;
   logic             half_ff, half_in;
   logic             is_final;

   // state and loop counters
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         k_ff     <= '0;
         i_ff     <= '0;
         j_ff     <= '0;
         half_ff  <= 1'b0;
      end else begin
         state_ff <= state_in;
         k_ff     <= k_in;
         i_ff     <= i_in;
         j_ff     <= j_in;
         half_ff  <= half_in;
      end
   end

   assign is_final = half_ff && (i_ff == LAST_IDX) && (j_ff == LAST_IDX);

   // next state and commands
   always_comb begin
      state_in      = state_ff;
      k_in          = k_ff;
      i_in          = i_ff;
      j_in          = j_ff;
      half_in       = half_ff;
      req_ready     = 1'b0;
      cmd.op        = OP_IDLE;
      cmd.k         = k_ff;
      cmd.i         = i_ff;
      cmd.j         = j_ff;
      cmd.half      = half_ff;
      cmd.final_res = 1'b0;
      unique case (state_ff)
         ST_IDLE: begin
            req_ready = !reset;
            if (req_fire && req_last) begin
               cmd.op   = OP_START;
               state_in = ST_COPY;
               k_in     = '0;
               j_in     = '0;
            end
         end
         ST_COPY: begin
            cmd.op = OP_COPY;
            if (j_ff == LAST_IDX) begin
               if (k_ff == LAST_IDX) begin
                  state_in = ST_EMIT;
                  half_in  = 1'b0;
                  i_in     = '0;
                  j_in     = '0;
               end else begin
                  state_in = ST_DIV_START;
                  i_in     = k_ff + 1'b1;
               end
            end else begin
               j_in = j_ff + 1'b1;
            end
         end
         ST_DIV_START: begin
            cmd.op   = OP_DIV_START;
            state_in = ST_DIV_RUN;
         end
         ST_DIV_RUN: begin
            cmd.op = OP_DIV_RUN;
            if (status.div_done) state_in = ST_WRITE_L;
         end
         ST_WRITE_L: begin
            cmd.op   = OP_WRITE_L;
            j_in     = k_ff;
            state_in = ST_MUL;
         end
         ST_MUL: begin
            cmd.op   = OP_MUL;
            state_in = ST_RND;
         end
         ST_RND: begin
            cmd.op   = OP_RND;
            state_in = ST_SUB;
         end
         ST_SUB: begin
            cmd.op = OP_SUB;
            if (j_ff == LAST_IDX) begin
               if (i_ff == LAST_IDX) begin
                  k_in     = k_ff + 1'b1;
                  j_in     = k_ff + 1'b1;
                  state_in = ST_COPY;
               end else begin
                  i_in     = i_ff + 1'b1;
                  state_in = ST_DIV_START;
               end
            end else begin
               j_in     = j_ff + 1'b1;
               state_in = ST_MUL;
            end
         end
         ST_EMIT: begin
            cmd.op        = OP_EMIT;
            cmd.final_res = is_final;
            if (status.out_free) begin
               if (is_final) begin
                  state_in = ST_IDLE;
               end else if (j_ff == LAST_IDX) begin
                  j_in = '0;
                  if (i_ff == LAST_IDX) begin
                     i_in    = '0;
                     half_in = 1'b1;
                  end else begin
                     i_in = i_ff + 1'b1;
                  end
               end else begin
                  j_in = j_ff + 1'b1;
               end
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

endmodule
`default_nettype wire

>>> rtl/luddl_datapath.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// luddl_datapath: matrix stores, serial divider, multiplier and output stage
// Executes one controller op per cycle and holds the result word register.
// ----------------------------------------------------------------------------
module luddl_datapath #(
   parameter int MATRIX_SIZE = 3
) (
   input  wire                      clock,
   input  wire                      reset,
   input  wire                      req_fire,
   input  wire                      req_last,
   input  wire  [31:0]              req_element,
   input  luddl_pkg::dp_cmd_type    cmd,
   output luddl_pkg::dp_status_type status,
   input  wire                      rsp_ready,
   output logic                     rsp_valid,
   output logic [31:0]              rsp_value,
   output logic                     rsp_is_upper,
   output logic [1:0]               rsp_row,
   output logic [1:0]               rsp_column,
   output logic                     rsp_zero_pivot,
   output logic                     rsp_final
);
   import luddl_pkg::*;

   localparam int CELLS  = MATRIX_SIZE * MATRIX_SIZE;
   localparam int CELL_W = $clog2(CELLS);
   localparam int CNT_W  = $clog2(CELLS + 1);

   function automatic logic [CELL_W-1:0] cell_addr(input logic [IDX_W-1:0] r,
                                                   input logic [IDX_W-1:0] c);
      return CELL_W'(int'(r) * MATRIX_SIZE + int'(c));
   endfunction

   logic signed [VAL_W-1:0] work_ff  [CELLS];
   logic signed [VAL_W-1:0] lower_ff [CELLS];
   logic signed [VAL_W-1:0] upper_ff [CELLS];
   logic [CNT_W-1:0]        load_cnt_ff;
   logic                    pivot_err_ff;
   logic signed [VAL_W-1:0] pivot_ff;
   logic signed [VAL_W-1:0] mult_ff;
   logic signed [VAL_W-1:0] a_ff;
   logic signed [63:0]      prod_ff;
   logic signed [47:0]      round_ff;
   // serial divider
   logic [31:0]             rem_ff, rem_in;
   logic [47:0]             dvd_ff, dvd_in;
   logic [31:0]             dvs_ff;
   logic                    neg_ff;
   logic [DCNT_W-1:0]       dcnt_ff;
   // output word
   logic                    out_valid_ff;
   logic [VAL_W-1:0]        out_value_ff;
   logic                    out_upper_ff, out_zp_ff, out_final_ff;
   logic [IDX_W-1:0]        out_row_ff, out_col_ff;

   logic [CELL_W-1:0]       work_addr, upper_addr, emit_addr;
   logic signed [VAL_W-1:0] work_rd, upper_rd, lower_rd;
   logic [VAL_W-1:0]        abs_a, abs_d;
   logic [32:0]             rem_sh, rem_diff;
   logic                    take;
   logic signed [VAL_W-1:0] quot_sat;
   logic signed [63:0]      prod_rnd;
   logic signed [48:0]      upd_full;
   logic signed [VAL_W-1:0] upd_sat;
   logic [VAL_W-1:0]        emit_value;
   logic                    out_free, out_load;

   // read address selection
   always_comb begin
      priority case (cmd.op)
         OP_COPY:      work_addr = cell_addr(cmd.k, cmd.j);
         OP_DIV_START: work_addr = cell_addr(cmd.i, cmd.k);
         default:      work_addr = cell_addr(cmd.i, cmd.j);
      endcase
   end
   assign upper_addr = (cmd.op == OP_EMIT) ? cell_addr(cmd.i, cmd.j)
                                           : cell_addr(cmd.k, cmd.j);
   assign emit_addr  = cell_addr(cmd.i, cmd.j);
   assign work_rd    = work_ff[work_addr];
   assign upper_rd   = upper_ff[upper_addr];
   assign lower_rd   = lower_ff[emit_addr];

   // divider step: restoring, one quotient bit a cycle
   assign abs_a    = work_rd[VAL_W-1] ? 32'(-work_rd) : 32'(work_rd);
   assign abs_d    = pivot_ff[VAL_W-1] ? 32'(-pivot_ff) : 32'(pivot_ff);
   assign rem_sh   = {rem_ff, dvd_ff[47]};
   assign take     = rem_sh >= {1'b0, dvs_ff};
   assign rem_diff = rem_sh - {1'b0, dvs_ff};
   assign rem_in   = take ? rem_diff[31:0] : rem_sh[31:0];
   assign dvd_in   = {dvd_ff[46:0], take};

   // quotient sign and saturation
   always_comb begin
      if (neg_ff) begin
         quot_sat = (dvd_ff > 48'h0000_8000_0000) ? 32'sh8000_0000
                                                  : 32'(-dvd_ff[31:0]);
      end else begin
         quot_sat = (dvd_ff > 48'h0000_7FFF_FFFF) ? 32'sh7FFF_FFFF
                                                  : 32'(dvd_ff[31:0]);
      end
   end

   // product rounding and saturated update
   assign prod_rnd = prod_ff + 64'sd32768;
   assign upd_full = 49'(a_ff) - 49'(round_ff);
   always_comb begin
      if (upd_full > 49'sh0_7FFF_FFFF)       upd_sat = 32'sh7FFF_FFFF;
      else if (upd_full < -49'sh0_8000_0000) upd_sat = 32'sh8000_0000;
      else                                   upd_sat = upd_full[31:0];
   end

   // stores and arithmetic registers
   always_ff @(posedge clock) begin
      if (req_fire && (load_cnt_ff < CNT_W'(CELLS)))
         work_ff[load_cnt_ff[CELL_W-1:0]] <= req_element;
      unique case (cmd.op)
         OP_COPY: begin
            upper_ff[cell_addr(cmd.k, cmd.j)] <= work_rd;
            if (cmd.j == cmd.k) pivot_ff <= work_rd;
         end
         OP_DIV_START: begin
            neg_ff <= work_rd[VAL_W-1] ^ pivot_ff[VAL_W-1];
            dvd_ff <= {abs_a, 16'h0000};
            dvs_ff <= abs_d;
            rem_ff <= '0;
         end
         OP_DIV_RUN: begin
            if (dcnt_ff != '0) begin
               dvd_ff <= dvd_in;
               rem_ff <= rem_in;
            end
         end
         OP_WRITE_L: begin
            mult_ff <= (pivot_ff == '0) ? '0 : quot_sat;
            lower_ff[cell_addr(cmd.i, cmd.k)] <= (pivot_ff == '0) ? '0 : quot_sat;
         end
         OP_MUL: begin
            prod_ff <= 64'(mult_ff) * 64'(upper_rd);
            a_ff    <= work_rd;
         end
         OP_RND:  round_ff <= 48'(prod_rnd >>> 16);
         OP_SUB:  work_ff[cell_addr(cmd.i, cmd.j)] <= upd_sat;
         default: ;
      endcase
   end

   // control registers: load count, pivot flag, divide counter
   always_ff @(posedge clock) begin
      if (reset) begin
         load_cnt_ff  <= '0;
         pivot_err_ff <= 1'b0;
         dcnt_ff      <= '0;
      end else begin
         if (req_fire) begin
            if (req_last)                           load_cnt_ff <= '0;
            else if (load_cnt_ff < CNT_W'(CELLS))   load_cnt_ff <= load_cnt_ff + 1'b1;
         end
         if (cmd.op == OP_START)
            pivot_err_ff <= 1'b0;
         else if (cmd.op == OP_COPY && cmd.j == cmd.k && work_rd == '0)
            pivot_err_ff <= 1'b1;
         if (cmd.op == OP_DIV_START)
            dcnt_ff <= DCNT_W'(DIV_STEPS);
         else if (cmd.op == OP_DIV_RUN && dcnt_ff != '0)
            dcnt_ff <= dcnt_ff - 1'b1;
      end
   end

   // fixed entries of L and U come from the indices
   always_comb begin
      if (cmd.half)
         emit_value = (cmd.j < cmd.i) ? '0 : upper_rd;
      else if (cmd.i == cmd.j)
         emit_value = ONE_Q16;
      else
         emit_value = (cmd.j > cmd.i) ? '0 : lower_rd;
   end

   // output word register
   assign out_free = !out_valid_ff || rsp_ready;
   assign out_load = (cmd.op == OP_EMIT) && out_free;

   always_ff @(posedge clock) begin
      if (reset) out_valid_ff <= 1'b0;
      else if (out_load) out_valid_ff <= 1'b1;
      else if (rsp_ready) out_valid_ff <= 1'b0;
   end

   always_ff @(posedge clock) begin
      if (out_load) begin
         out_value_ff <= emit_value;
         out_upper_ff <= cmd.half;
         out_row_ff   <= cmd.i;
         out_col_ff   <= cmd.j;
         out_zp_ff    <= pivot_err_ff;
         out_final_ff <= cmd.final_res;
      end
   end

   assign status.div_done = (dcnt_ff == '0);
   assign status.out_free = out_free;
   assign rsp_valid      = out_valid_ff;
   assign rsp_value      = out_value_ff;
   assign rsp_is_upper   = out_upper_ff;
   assign rsp_row        = out_row_ff;
   assign rsp_column     = out_col_ff;
   assign rsp_zero_pivot = out_zp_ff;
   assign rsp_final      = out_final_ff;

endmodule
`default_nettype wire

>>> rtl/lu_decomposition_doolittle.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// lu_decomposition_doolittle: Doolittle LU decomposition, no pivoting, Q16.16
// Loads an N x N matrix row-major and streams out L then U.
// ----------------------------------------------------------------------------
// Usage:
//  - req_*: one matrix element per word, row-major; tlast on the final one
//    starts decomposition. Words past N*N before tlast are dropped.
//  - Loading takes one word a cycle. After tlast, req_tready stays low
//    until the last of the 2*N*N result words is in the output register.
//  - Each multiplier uses the serial divider: start, run, then write to L.
//    Each updated element takes a multiply, a round and a subtract step.
//    Each row of U is copied out of the working matrix in turn.
//  - rsp_*: N*N words of L then N*N of U, row-major, one per cycle while
//    rsp_tready is high; rsp_tlast on the last U word. A stall holds the
//    output register and the sequencer.
//  - Reset clears the sequencer, load count and pivot flag and holds
//    req_tready low; the matrix stores hold no defined value until loaded.
// ----------------------------------------------------------------------------
module lu_decomposition_doolittle #(
   parameter int MATRIX_SIZE = 3
) (
   input  wire         clock,
   input  wire         reset,
   input  wire         req_tvalid,
   output logic        req_tready,
   input  wire  [31:0] req_tdata,   // [31:0] element
   input  wire         req_tlast,
   output logic        rsp_tvalid,
   input  wire         rsp_tready,
   output logic [39:0] rsp_tdata,   // [31:0] value, [33:32] row, [35:34] column
   output logic [1:0]  rsp_tuser,   // [0] is_upper, [1] zero_pivot
   output logic        rsp_tlast
);
   import luddl_pkg::*;

   dp_cmd_type    cmd;
   dp_status_type status;
   logic          req_fire;
   logic [31:0]   value;
   logic [1:0]    row, column;
   logic          is_upper, zero_pivot;

   assign req_fire = req_tvalid && req_tready;

   luddl_ctrl #(.MATRIX_SIZE(MATRIX_SIZE)) u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_fire  (req_fire),
      .req_last  (req_tlast),
      .req_ready (req_tready),
      .status    (status),
      .cmd       (cmd)
   );

   luddl_datapath #(.MATRIX_SIZE(MATRIX_SIZE)) u_datapath (
      .clock          (clock),
      .reset          (reset),
      .req_fire       (req_fire),
      .req_last       (req_tlast),
      .req_element    (req_tdata),
      .cmd            (cmd),
      .status         (status),
      .rsp_ready      (rsp_tready),
      .rsp_valid      (rsp_tvalid),
      .rsp_value      (value),
      .rsp_is_upper   (is_upper),
      .rsp_row        (row),
      .rsp_column     (column),
      .rsp_zero_pivot (zero_pivot),
      .rsp_final      (rsp_tlast)
   );

   assign rsp_tdata = {4'h0, column, row, value};
   assign rsp_tuser = {zero_pivot, is_upper};

`ifndef SYNTH
   a_busy_after_last: assert property (@(posedge clock) disable iff (reset)
      req_tvalid && req_tready && req_tlast |=> !req_tready)
      else $error("input taken while decomposing");

   a_idle_after_final: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tready && rsp_tlast |=> !rsp_tvalid)
      else $error("result word after final word");

   a_unit_diag: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tuser[0] && (rsp_tdata[33:32] == rsp_tdata[35:34])
      |-> rsp_tdata[31:0] == ONE_Q16)
      else $error("L diagonal is not one");
`endif

endmodule
`default_nettype wire

>>> verif/lu_result_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lu_result_checker: scoreboard for the LU decomposition block
// Watches the element and result streams, keeps its own copy of the matrix
// and computes the L and U entries each matrix should give. Every result
// word is compared field by field with the oldest entry still owed.
// ----------------------------------------------------------------------------
module lu_result_checker #(
   parameter int N = 3
) (
   input  wire         clock,
   input  wire         reset,
   input  wire         req_tvalid,
   input  wire         req_tready,
   input  wire  [31:0] req_tdata,   // [31:0] element
   input  wire         req_tlast,
   input  wire         rsp_tvalid,
   input  wire         rsp_tready,
   input  wire  [39:0] rsp_tdata,   // [31:0] value, [33:32] row, [35:34] column
   input  wire  [1:0]  rsp_tuser,   // [0] is_upper, [1] zero_pivot
   input  wire         rsp_tlast,
   output int          error_count,
   output int          owed_count,
   output int          results_seen
);

   localparam int CELLS = N * N;
   localparam int ONE_Q16 = 32'h0001_0000;

   typedef struct packed {
      logic [31:0] value;
      logic        is_upper;
      logic [1:0]  row;
      logic [1:0]  column;
      logic        zero_pivot;
      logic        final_res;
   } lu_entry_t;

   int        matrix_cells [CELLS];
   int        l_cells      [CELLS];
   int        u_cells      [CELLS];
   int        fill_pos;
   logic      pivot_zero;
   lu_entry_t owed_entries [$];

   function automatic int sat32(longint v);
      if (v > 64'sd2147483647) return 32'h7fff_ffff;
      if (v < -64'sd2147483648) return 32'h8000_0000;
      return int'(v);
   endfunction

   // rounded Q16.16 product: add half an lsb, then floor
   function automatic longint q16_product(int a, int b);
      longint p;
      p = longint'(a) * longint'(b) + 64'sd32768;
      return p >>> 16;
   endfunction

   // Q16.16 quotient, truncated toward zero and saturated
   function automatic int q16_quotient(int a, int d);
      longint num;
      num = longint'(a) * 64'sd65536;
      return sat32(num / longint'(d));
   endfunction

   // Doolittle elimination in place on matrix_cells, fills L and U
   task automatic factor_matrix();
      int   piv;
      int   m;
      pivot_zero = 1'b0;
      for (int c = 0; c < CELLS; c++) begin
         l_cells[c] = 0;
         u_cells[c] = 0;
      end
      for (int d = 0; d < N; d++) l_cells[d*N+d] = ONE_Q16;
      for (int k = 0; k < N; k++) begin
         for (int j = k; j < N; j++) u_cells[k*N+j] = matrix_cells[k*N+j];
         piv = u_cells[k*N+k];
         if (piv == 0) pivot_zero = 1'b1;
         for (int i = k + 1; i < N; i++) begin
            m = (piv != 0) ? q16_quotient(matrix_cells[i*N+k], piv) : 0;
            l_cells[i*N+k] = m;
            for (int j = k; j < N; j++)
               matrix_cells[i*N+j] = sat32(longint'(matrix_cells[i*N+j])
                                           - q16_product(m, u_cells[k*N+j]));
         end
      end
   endtask

   // queue L then U, row-major, final flag on the last U word
   task automatic queue_results();
      lu_entry_t e;
      for (int h = 0; h < 2; h++)
         for (int r = 0; r < N; r++)
            for (int c = 0; c < N; c++) begin
               e.value      = h ? u_cells[r*N+c] : l_cells[r*N+c];
               e.is_upper   = h[0];
               e.row        = r[1:0];
               e.column     = c[1:0];
               e.zero_pivot = pivot_zero;
               e.final_res  = (h == 1) && (r == N-1) && (c == N-1);
               owed_entries.push_back(e);
            end
   endtask

   // element side: load and, on the last word, predict
   always @(posedge clock) begin
      if (reset) begin
         fill_pos <= 0;
      end else if (req_tvalid && req_tready) begin
         if (fill_pos < CELLS) matrix_cells[fill_pos] = req_tdata;
         if (req_tlast) begin
            factor_matrix();
            queue_results();
            owed_count = owed_entries.size();
            fill_pos <= 0;
         end else if (fill_pos < CELLS) begin
            fill_pos <= fill_pos + 1;
         end
      end
   end

   // result side: compare against the oldest owed word
   always @(posedge clock) begin
      lu_entry_t want;
      lu_entry_t got;
      if (reset) begin
         error_count  <= 0;
         results_seen <= 0;
      end else if (rsp_tvalid && rsp_tready) begin
         got.value      = rsp_tdata[31:0];
         got.row        = rsp_tdata[33:32];
         got.column     = rsp_tdata[35:34];
         got.is_upper   = rsp_tuser[0];
         got.zero_pivot = rsp_tuser[1];
         got.final_res  = rsp_tlast;
         results_seen  <= results_seen + 1;
         if (owed_entries.size() == 0) begin
            $display("%0t: unexpected result word value=%h upper=%0d r=%0d c=%0d",
                     $time, got.value, got.is_upper, got.row, got.column);
            error_count <= error_count + 1;
         end else begin
            want = owed_entries.pop_front();
            owed_count = owed_entries.size();
            if (got !== want) begin
               $display("%0t: mismatch expected value=%h upper=%0d r=%0d c=%0d zp=%0d last=%0d",
                        $time, want.value, want.is_upper, want.row, want.column,
                        want.zero_pivot, want.final_res);
               $display("%0t:          actual   value=%h upper=%0d r=%0d c=%0d zp=%0d last=%0d",
                        $time, got.value, got.is_upper, got.row, got.column,
                        got.zero_pivot, got.final_res);
               error_count <= error_count + 1;
            end
         end
      end
   end

endmodule

>>> verif/tb_lu_decomposition_doolittle.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_lu_decomposition_doolittle: stimulus and verdict for the LU block
// Sends directed then random matrices (full, short and overlong) under
// varying stall patterns; the checker predicts and compares results.
// ----------------------------------------------------------------------------
module tb_lu_decomposition_doolittle;

   localparam int N = 3;
   localparam int STALL_LIMIT = 5000;
   localparam int Q1 = 32'h0001_0000;

   logic        clock;
   logic        reset;
   logic        req_tvalid;
   logic        req_tready;
   logic [31:0] req_tdata;    // [31:0] element
   logic        req_tlast;
   logic        rsp_tvalid;
   logic        rsp_tready;
   logic [39:0] rsp_tdata;    // [31:0] value, [33:32] row, [35:34] column
   logic [1:0]  rsp_tuser;    // [0] is_upper, [1] zero_pivot
   logic        rsp_tlast;

   int error_count;
   int owed_count;
   int results_seen;
   int words_sent;
   int matrices_sent;
   int tx_idle_pct;
   int rx_idle_pct;
   int rx_hold;
   int quiet_cycles;

   lu_decomposition_doolittle #(.MATRIX_SIZE(N)) i_dut (
      .clock(clock), .reset(reset),
      .req_tvalid(req_tvalid), .req_tready(req_tready),
      .req_tdata(req_tdata), .req_tlast(req_tlast),
      .rsp_tvalid(rsp_tvalid), .rsp_tready(rsp_tready),
      .rsp_tdata(rsp_tdata), .rsp_tuser(rsp_tuser), .rsp_tlast(rsp_tlast)
   );

   lu_result_checker #(.N(N)) i_checker (
      .clock(clock), .reset(reset),
      .req_tvalid(req_tvalid), .req_tready(req_tready),
      .req_tdata(req_tdata), .req_tlast(req_tlast),
      .rsp_tvalid(rsp_tvalid), .rsp_tready(rsp_tready),
      .rsp_tdata(rsp_tdata), .rsp_tuser(rsp_tuser), .rsp_tlast(rsp_tlast),
      .error_count(error_count), .owed_count(owed_count),
      .results_seen(results_seen)
   );

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   // result side ready: long hold-off when asked, else random stalls
   initial begin
      rsp_tready = 1'b0;
      forever begin
         @(negedge clock);
         if (rx_hold > 0) begin
            rsp_tready <= 1'b0;
            rx_hold = rx_hold - 1;
         end else begin
            rsp_tready <= ($urandom_range(99) >= rx_idle_pct);
         end
      end
   end

   // watchdog on cycles with no word moving on either side
   initial begin
      quiet_cycles = 0;
      forever begin
         @(posedge clock);
         if (reset || (req_tvalid && req_tready) || (rsp_tvalid && rsp_tready))
            quiet_cycles = 0;
         else
            quiet_cycles = quiet_cycles + 1;
         if (quiet_cycles >= STALL_LIMIT) begin
            $display("%0t: no progress for %0d cycles, %0d words owed",
                     $time, STALL_LIMIT, owed_count);
            $display("FAILED: results differ");
            $finish;
         end
      end
   end

   // one element word, with an optional gap in front
   task automatic send_word(logic [31:0] elem, logic last);
      if ($urandom_range(99) < tx_idle_pct) begin
         req_tvalid <= 1'b0;
         repeat ($urandom_range(1, 4)) @(negedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata  <= elem;
      req_tlast  <= last;
      @(posedge clock);
      while (!req_tready) @(posedge clock);
      words_sent = words_sent + 1;
      if (last) matrices_sent = matrices_sent + 1;
      @(negedge clock);
   endtask

   task automatic send_matrix(int cells [$]);
      foreach (cells[i]) send_word(cells[i], i == cells.size() - 1);
   endtask

   function automatic logic [31:0] rand_element();
      int pick;
      pick = $urandom_range(9);
      if (pick < 6) return $urandom_range(32'h0008_0000) - 32'h0004_0000;
      if (pick < 8) return $urandom;
      if (pick == 8) return 32'h0;
      return $urandom_range(1) ? 32'h7fff_ffff : 32'h8000_0000;
   endfunction

   // random matrix: mostly full, some short, some overlong
   task automatic send_random_matrix();
      int len;
      int pick;
      int cells [$];
      pick = $urandom_range(9);
      if (pick < 8) len = N * N;
      else if (pick == 8) len = $urandom_range(1, N * N - 1);
      else len = $urandom_range(N * N + 1, N * N + 3);
      for (int i = 0; i < len; i++) cells.push_back(rand_element());
      send_matrix(cells);
   endtask

   task automatic drain();
      req_tvalid <= 1'b0;
      wait (owed_count == 0);
      @(negedge clock);
   endtask

   initial begin
      reset       = 1'b1;
      req_tvalid  = 1'b0;
      req_tdata   = '0;
      req_tlast   = 1'b0;
      tx_idle_pct = 0;
      rx_idle_pct = 0;
      rx_hold     = 0;
      words_sent  = 0;
      matrices_sent = 0;
      repeat (12) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      // directed: extremes with zero first pivot, fills every position
      send_matrix('{32'h0, 32'h7fff_ffff, 32'h8000_0000,
                    32'h7fff_ffff, 32'h8000_0000, 32'hffff_ffff,
                    32'h8000_0000, 32'h0000_0001, 32'h7fff_ffff});
      // tiny pivot: multipliers saturate both ways
      send_matrix('{32'h0000_0001, 32'h0000_0002, Q1,
                    32'h7fff_ffff, Q1, 32'h0,
                    32'h8000_0000, 32'h0, Q1});
      // singular matrix: zero pivot in the middle column
      send_matrix('{Q1, 2*Q1, 3*Q1, 2*Q1, 4*Q1, 5*Q1, Q1, Q1, Q1});
      drain();
      // short matrix, then one with extra words past the end
      send_matrix('{-Q1, Q1/2, 32'h1234_5678});
      send_matrix('{Q1, Q1, Q1, Q1, 3*Q1, Q1, 2*Q1, Q1, 5*Q1,
                    32'hdead_beef});
      drain();

      // sender idles more rarely than the receiver
      tx_idle_pct = 20;
      rx_idle_pct = 47;
      for (int m = 0; m < 1; m++) send_random_matrix();
      // receiver holds off long enough to back up the input
      rx_hold = 600;
      send_random_matrix();
      send_random_matrix();
      drain();

      tx_idle_pct = 47;
      rx_idle_pct = 20;
      for (int m = 0; m < 3; m++) send_random_matrix();
      drain();

      tx_idle_pct = 0;
      rx_idle_pct = 0;
      for (int m = 0; m < 2; m++) send_random_matrix();
      drain();

      repeat (200) @(posedge clock);
      $display("Covered %0d element words in %0d matrices, %0d result words checked,",
               words_sent, matrices_sent, results_seen);
      $display("including zero pivots, saturation, short and overlong loads.");
      if (error_count == 0 && owed_count == 0)
         $display("PASSED: all results match");
      else
         $display("FAILED: results differ");
      $finish;
   end

endmodule

>>> sim.f
rtl/luddl_pkg.sv
rtl/luddl_ctrl.sv
rtl/luddl_datapath.sv
rtl/lu_decomposition_doolittle.sv
verif/lu_result_checker.sv
verif/tb_lu_decomposition_doolittle.sv
